@@ hdl/rpnsam_pkg.sv @@
// rpnsam_pkg: action and status codes, fixed-point constants and the sequencer state type
// for the reverse-polish stack calculator; no dependencies
package rpnsam_pkg;

   localparam int ACTION_W    = 3;
   localparam int STATUS_W    = 3;
   localparam int FRAC_BITS   = 16;
   localparam int MUL_DIGIT_W = 8;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FEW     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_MUL
   } state_type;

endpackage

@@ hdl/rpn_stack_add_multiply_top.sv @@
// rpn_stack_add_multiply_top: bounded reverse-polish operand stack with saturating
// fixed-point add and multiply; depends on rpnsam_pkg and rpnsam_mul
//
// usage
//    request channel (req_*): one transaction carries an action (push, pop, peek, add,
//    multiply) and a signed Q16.16 value, used by push only
//    response channel (rsp_*): exactly one transaction per request, in order, giving the
//    status, the top of the stack (zero when empty), a top-valid flag and the depth
//    sequencing
//    push, pop, peek, add and error cases: the accept cycle issues the read of the
//    second entry of the stack memory, and the exec state commits once the output
//    register is free; multiply hands the operands to the iterative multiplier, which
//    retires one 8-bit digit of the operand per cycle, and commits when it is done
//    the top of the stack is kept in a register, entries below it in a one-port-read
//    memory with a registered read; one request is in flight at a time, so a write
//    always lands before the next read
//    the response sits in an output register; a new request may be accepted while it
//    waits, and when rsp_stall holds it the next commit waits for it to be taken
//    reset clears the depth, the sequencer and the response valid; memory contents
//    are left as they are and never used before being written
module rpn_stack_add_multiply_top #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32,
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpnsam_pkg::ACTION_W-1:0]     req_action,
   input  logic signed [VALUE_WIDTH-1:0]       req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rpnsam_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [VALUE_WIDTH-1:0]       rsp_top_value,
   output logic                                rsp_top_valid,
   output logic [CNT_W-1:0]                    rsp_depth_used
);
   import rpnsam_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   // stack memory, entries 0 .. count-1, top mirrored in top_ff
   logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in;
   logic [ACTION_W-1:0]    act_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] rdata_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_top_value_ff;
   logic                   rsp_top_valid_ff;
   logic [CNT_W-1:0]       rsp_depth_used_ff;

   logic                   req_accept;
   logic                   out_free;
   logic                   two_held;
   logic [ADDR_W-1:0]      second_addr;
   logic                   mul_go;
   logic                   mul_start;
   logic                   mul_done;
   logic [VALUE_WIDTH-1:0] mul_result;
   logic                   commit_en;

   logic [VALUE_WIDTH-1:0] add_sum, add_res, op_res;
   logic [STATUS_W-1:0]    status_c;
   logic                   wr_req;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign two_held    = count_ff >= CNT_W'(2);
   assign second_addr = two_held ? ADDR_W'(count_ff - CNT_W'(2)) : '0;
   assign mul_go      = (act_ff == ACT_MUL) && two_held;

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (mul_go)        state_in = S_MUL;
            else if (out_free) state_in = S_IDLE;
         end
         S_MUL: begin
            if (mul_done && out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      mul_start = 1'b0;
      commit_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_EXEC: begin
            mul_start = mul_go;
            commit_en = !mul_go && out_free;
         end
         S_MUL: begin
            commit_en = mul_done && out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   rpnsam_mul #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mul_a  (top_ff),
      .mul_b  (rdata_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   // saturating add of the two top entries
   always_comb begin
      add_sum = top_ff + rdata_ff;
      add_res = add_sum;
      if ((top_ff[VALUE_WIDTH-1] == rdata_ff[VALUE_WIDTH-1]) &&
          (add_sum[VALUE_WIDTH-1] != top_ff[VALUE_WIDTH-1])) begin
         add_res = top_ff[VALUE_WIDTH-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                         : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   end

   assign op_res = (act_ff == ACT_MUL) ? mul_result : add_res;

   // commit: status, new depth, new top and the memory write
   always_comb begin
      status_c = STAT_OK;
      count_in = count_ff;
      top_in   = top_ff;
      wr_req   = 1'b0;
      wr_addr  = second_addr;
      wr_data  = op_res;
      case (act_ff)
         ACT_PUSH: begin
            if (count_ff == CNT_W'(STACK_DEPTH)) begin
               status_c = STAT_FULL;
            end else begin
               wr_req   = 1'b1;
               wr_addr  = count_ff[ADDR_W-1:0];
               wr_data  = value_ff;
               top_in   = value_ff;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP: begin
            if (count_ff == '0) begin
               status_c = STAT_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               if (two_held) top_in = rdata_ff;
            end
         end
         ACT_PEEK: begin
            if (count_ff == '0) status_c = STAT_EMPTY;
         end
         ACT_ADD, ACT_MUL: begin
            if (!two_held) begin
               status_c = STAT_FEW;
            end else begin
               wr_req   = 1'b1;
               top_in   = op_res;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_c = STAT_INVALID;
         end
      endcase
   end

   assign wr_en = commit_en && wr_req;

   // stack memory: one write port, registered read of the second entry at accept
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      if (req_accept) rdata_ff <= stack_mem[second_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit_en) count_ff <= count_in;
         if (commit_en)      rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         act_ff   <= req_action;
         value_ff <= req_value;
      end
      if (commit_en) begin
         top_ff            <= top_in;
         rsp_status_ff     <= status_c;
         rsp_top_value_ff  <= (count_in != '0) ? top_in : '0;
         rsp_top_valid_ff  <= (count_in != '0);
         rsp_depth_used_ff <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_top_value  = rsp_top_value_ff;
   assign rsp_top_valid  = rsp_top_valid_ff;
   assign rsp_depth_used = rsp_depth_used_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_depth_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      !commit_en |=> $stable(count_ff))
      else $error("stack depth changed without a commit");

   a_mul_needs_two: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> two_held)
      else $error("multiply started with fewer than two operands");

   a_rsp_flags_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_top_valid_ff == (rsp_depth_used_ff != '0)))
      else $error("response top-valid disagrees with depth");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit_en |=> rsp_valid_ff)
      else $error("commit produced no response");

endmodule

@@ hdl/rpnsam_mul.sv @@
// rpnsam_mul: iterative signed fixed-point multiplier, one digit of the operand per cycle,
// rounding to nearest (ties away from zero) and saturation; depends on rpnsam_pkg
module rpnsam_mul #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] mul_a,
   input  logic [VALUE_WIDTH-1:0] mul_b,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);
   import rpnsam_pkg::*;

   localparam int MUL_STEPS = (VALUE_WIDTH + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
   localparam int B_W       = MUL_STEPS * MUL_DIGIT_W;
   localparam int PROD_W    = 2 * VALUE_WIDTH;
   localparam int Q_W       = PROD_W + 1;
   localparam int STEP_W    = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
   localparam int PART_W    = VALUE_WIDTH + MUL_DIGIT_W;

   logic [VALUE_WIDTH-1:0] mag_a_ff, mag_a_in;
   logic [B_W-1:0]         mag_b_ff, mag_b_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [VALUE_WIDTH-1:0] abs_a, abs_b;
   logic [PART_W-1:0]      partial;
   logic [Q_W-1:0]         rnd_sum, quot, limit, quot_sat;
   logic [VALUE_WIDTH-1:0] mag_res;

   assign abs_a   = mul_a[VALUE_WIDTH-1] ? (~mul_a + 1'b1) : mul_a;
   assign abs_b   = mul_b[VALUE_WIDTH-1] ? (~mul_b + 1'b1) : mul_b;
   assign partial = PART_W'(mag_a_ff) * PART_W'(mag_b_ff[B_W-1 -: MUL_DIGIT_W]);

   // most significant digit first: shift the partial sum up, add the next row
   always_comb begin
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (start) begin
         mag_a_in = abs_a;
         mag_b_in = B_W'(abs_b);
         acc_in   = '0;
         neg_in   = mul_a[VALUE_WIDTH-1] ^ mul_b[VALUE_WIDTH-1];
         step_in  = STEP_W'(MUL_STEPS - 1);
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         acc_in   = (acc_ff << MUL_DIGIT_W) + PROD_W'(partial);
         mag_b_in = mag_b_ff << MUL_DIGIT_W;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      step_ff  <= step_in;
   end

   // round on the magnitude, drop the fraction, clamp to the signed range
   always_comb begin
      rnd_sum  = {1'b0, acc_ff} + (Q_W'(1) << (FRAC_BITS - 1));
      quot     = rnd_sum >> FRAC_BITS;
      limit    = neg_ff ? (Q_W'(1) << (VALUE_WIDTH - 1))
                        : ((Q_W'(1) << (VALUE_WIDTH - 1)) - Q_W'(1));
      quot_sat = (quot > limit) ? limit : quot;
      mag_res  = quot_sat[VALUE_WIDTH-1:0];
   end

   assign result = neg_ff ? (~mag_res + 1'b1) : mag_res;
   assign done   = done_ff;

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("multiplier busy and done together");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("multiplier did not start");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == '0) |=> done_ff)
      else $error("multiplier missed its last step");

endmodule

@@ tb/rpn_stack_checker.sv @@
// rpn_stack_checker: watches both channels of the rpn stack calculator, predicts every
// response from its own copy of the operand stack and compares field by field
// depends on rpnsam_pkg for the action and status codes
module rpn_stack_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_top_value,
   input  logic        rsp_top_valid,
   input  logic [4:0]  rsp_depth_used,
   output int          mismatch_count,
   output int          results_owed
);
   import rpnsam_pkg::*;

   localparam int          DEPTH = 16;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] top_value;
      logic        top_valid;
      logic [4:0]  depth_used;
   } stack_view_t;

   logic [31:0] operand_stack [DEPTH];
   int          operand_count;
   stack_view_t expected_views [$];

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      operand_count  = 0;
   end

   function automatic logic [31:0] saturated_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31])
         return s[32] ? Q_MIN : Q_MAX;
      return s[31:0];
   endfunction

   // magnitude product, round half away from zero, clamp, then restore the sign
   function automatic logic [31:0] saturated_product(input logic [31:0] a,
                                                     input logic [31:0] b);
      logic        neg;
      logic [31:0] ma, mb;
      logic [64:0] rounded;
      logic [48:0] q, lim;
      neg     = a[31] ^ b[31];
      ma      = a[31] ? -a : a;
      mb      = b[31] ? -b : b;
      rounded = 65'({32'b0, ma} * {32'b0, mb}) + (65'd1 << (FRAC_BITS - 1));
      q       = 49'(rounded >> FRAC_BITS);
      lim     = neg ? 49'(Q_MIN) : 49'(Q_MAX);
      if (q > lim)
         q = lim;
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function automatic stack_view_t apply_action(input logic [2:0] act, input logic [31:0] val);
      stack_view_t view;
      view.status = STAT_OK;
      case (act)
         ACT_PUSH: begin
            if (operand_count >= DEPTH)
               view.status = STAT_FULL;
            else begin
               operand_stack[operand_count] = val;
               operand_count++;
            end
         end
         ACT_POP: begin
            if (operand_count == 0)
               view.status = STAT_EMPTY;
            else
               operand_count--;
         end
         ACT_PEEK: begin
            if (operand_count == 0)
               view.status = STAT_EMPTY;
         end
         ACT_ADD, ACT_MUL: begin
            if (operand_count < 2)
               view.status = STAT_FEW;
            else begin
               operand_stack[operand_count-2] = (act == ACT_ADD) ?
                  saturated_sum(operand_stack[operand_count-1], operand_stack[operand_count-2]) :
                  saturated_product(operand_stack[operand_count-1],
                                    operand_stack[operand_count-2]);
               operand_count--;
            end
         end
         default: view.status = STAT_INVALID;
      endcase
      view.top_value  = (operand_count > 0) ? operand_stack[operand_count-1] : '0;
      view.top_valid  = (operand_count > 0);
      view.depth_used = 5'(operand_count);
      return view;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic compare_response();
      stack_view_t want;
      if (expected_views.size() == 0) begin
         report_mismatch("response with none outstanding", '0, 32'(rsp_status));
         return;
      end
      want = expected_views.pop_front();
      if (rsp_status !== want.status)
         report_mismatch("status", 32'(want.status), 32'(rsp_status));
      if (rsp_top_value !== want.top_value)
         report_mismatch("top_value", want.top_value, rsp_top_value);
      if (rsp_top_valid !== want.top_valid)
         report_mismatch("top_valid", 32'(want.top_valid), 32'(rsp_top_valid));
      if (rsp_depth_used !== want.depth_used)
         report_mismatch("depth_used", 32'(want.depth_used), 32'(rsp_depth_used));
   endtask

   // a response taken at this edge always belongs to an earlier request
   always @(posedge clock) begin
      if (reset) begin
         operand_count = 0;
         expected_views.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_response();
         if (req_valid && !req_stall)
            expected_views.push_back(apply_action(req_action, req_value));
      end
      results_owed = expected_views.size();
   end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for the rpn stack calculator, directed cases then random
// streams under several idling mixes; depends on rpnsam_pkg, rpn_stack_add_multiply_top
// and rpn_stack_checker
module tb;
   import rpnsam_pkg::*;

   // codes 5 to 7 have no meaning to the block and must come back as invalid
   localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;
   localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN         = 32'h8000_0000;
   localparam logic [31:0] Q_LSB         = 32'h0000_0001;
   localparam logic [31:0] Q_MINUS_LSB   = 32'hFFFF_FFFF;
   localparam logic [31:0] Q_HALF        = 32'h0000_8000;
   localparam logic [31:0] Q_MINUS_HALF  = 32'hFFFF_8000;
   localparam int          PHASE_ITEMS   = 480;
   localparam int          BURST_ITEMS   = 40;
   localparam int          HOLD_CYCLES   = 80;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action     = '0;
   logic [31:0] req_value      = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_top_value;
   logic        rsp_top_valid;
   logic [4:0]  rsp_depth_used;

   int mismatch_count;
   int results_owed;

   // idling mix, changed by the stimulus between phases
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   // long hold-off requests; the receiver counts the hold itself
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   // fill bursts push hard so the stack hits full, drain bursts empty it again
   bit fill_mode;

   always #5 clock = ~clock;

   rpn_stack_add_multiply_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_top_value  (rsp_top_value),
      .rsp_top_valid  (rsp_top_valid),
      .rsp_depth_used (rsp_depth_used)
   );

   rpn_stack_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_top_value  (rsp_top_value),
      .rsp_top_valid  (rsp_top_valid),
      .rsp_depth_used (rsp_depth_used),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // response side: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // present one transaction; idle cycles carry junk on the payload with valid low,
   // and once valid is up the payload holds until the block takes it
   task automatic offer(input logic [2:0] act, input logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid  <= 1'b0;
         req_action <= 3'($urandom);
         req_value  <= $urandom;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // mostly values that keep products in range, with extremes and rounding ties mixed in
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
         4, 5:       return $urandom;
         6: begin
            case ($urandom_range(3))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return '0;
               default: return Q_MINUS_LSB;
            endcase
         end
         7:          return $urandom_range(1) ? Q_HALF : Q_MINUS_HALF;
         8:          return $urandom & 32'h0001_FFFF;
         default:    return $urandom >> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [2:0] pick_action();
      int r;
      r = $urandom_range(99);
      if (fill_mode) begin
         if (r < 85) return ACT_PUSH;
         if (r < 89) return ACT_POP;
         if (r < 92) return ACT_PEEK;
         if (r < 95) return ACT_ADD;
         if (r < 98) return ACT_MUL;
      end else begin
         if (r < 25) return ACT_PUSH;
         if (r < 45) return ACT_POP;
         if (r < 55) return ACT_PEEK;
         if (r < 75) return ACT_ADD;
         if (r < 95) return ACT_MUL;
      end
      return 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
   endfunction

   task automatic random_stream(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % BURST_ITEMS == 0)
            fill_mode = 1'($urandom_range(1));
         offer(pick_action(), pick_value());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // error cases on the empty stack
      offer(ACT_POP,       $urandom);
      offer(ACT_PEEK,      $urandom);
      offer(ACT_ADD,       $urandom);
      offer(ACT_MUL,       $urandom);
      offer(ACT_UNUSED_LO, $urandom);
      offer(3'(ACT_UNUSED_LO + 3'd1), $urandom);
      offer(ACT_UNUSED_HI, $urandom);
      // a single operand is not enough
      offer(ACT_PUSH, Q_MAX);
      offer(ACT_ADD,  '0);
      // positive and negative saturation of the sum
      offer(ACT_PUSH, Q_LSB);
      offer(ACT_ADD,  '0);
      offer(ACT_PUSH, Q_MIN);
      offer(ACT_ADD,  '0);
      offer(ACT_PUSH, Q_MIN);
      offer(ACT_ADD,  '0);
      // most negative squared overflows the product
      offer(ACT_PUSH, Q_MIN);
      offer(ACT_MUL,  '0);
      offer(ACT_POP,  '0);
      // half an lsb either side of zero: ties round away from zero
      offer(ACT_PUSH, Q_LSB);
      offer(ACT_PUSH, Q_HALF);
      offer(ACT_MUL,  '0);
      offer(ACT_PUSH, Q_MINUS_HALF);
      offer(ACT_MUL,  '0);
      offer(ACT_PEEK, '0);
      offer(ACT_POP,  '0);

      // back pressure: hold the response side off while requests keep coming
      hold_requests++;
      fill_mode = 1'b1;
      for (int i = 0; i < 30; i++)
         offer(pick_action(), pick_value());

      // idling mixes: none, sender mostly idle, receiver mostly stalling, both
      send_idle_pct = 0;  stall_pct = 0;  random_stream(PHASE_ITEMS);
      send_idle_pct = 81; stall_pct = 0;  random_stream(PHASE_ITEMS);
      send_idle_pct = 0;  stall_pct = 81; random_stream(PHASE_ITEMS);
      send_idle_pct = 33; stall_pct = 33; random_stream(PHASE_ITEMS);
      req_valid <= 1'b0;
      stall_pct = 0;

      // let the checker book the last transaction, drain, then leave room for a
      // stray late response
      @(negedge clock);
      while (results_owed != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ rpn_stack_add_multiply_top.f @@
hdl/rpnsam_pkg.sv
hdl/rpnsam_mul.sv
hdl/rpn_stack_add_multiply_top.sv
tb/rpn_stack_checker.sv
tb/tb.sv
